// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the trade signal block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CHK_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define CHK_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CHK_IMPLY(lbl, ck, rn, ante, cons)
`define CHK_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// File: rtl/core/ets_pkg.sv
// ----------------------------------------------------------------------------
// ets_pkg
// Shared widths, codes and types of the EMA trade signal block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ets_pkg;

	localparam int PRICE_W    = 32;
	localparam int QTY_W      = 20;
	localparam int ALPHA_W    = 16;
	localparam int RATIO_W    = 31;
	localparam int RATIO_FRAC = 30;
	localparam int BAL_W      = 64;
	localparam int POS_W      = 32;
	localparam int ID_W       = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	// derived product widths
	localparam int AVG_PROD_W = PRICE_W + ALPHA_W;
	localparam int THR_W      = PRICE_W + RATIO_W;
	localparam int CASH_W     = PRICE_W + QTY_W;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORDER_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BUY_RATIO  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SELL_RATIO = 2'd3;

	// configuration reset values
	localparam logic [ALPHA_W-1:0] ALPHA_RST      = 16'd6554;
	localparam logic [QTY_W-1:0]   ORDER_SIZE_RST = 20'd1;
	localparam logic [RATIO_W-1:0] BUY_RATIO_RST  = 31'd1073634450;
	localparam logic [RATIO_W-1:0] SELL_RATIO_RST = 31'd1073752561;

	// order side codes
	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG,
		ST_UPD,
		ST_MUL,
		ST_FIN
	} ets_state_t;

	typedef struct packed {
		logic load;     // capture accepted request
		logic avg_mul;  // alpha * |x - ema|
		logic ema_upd;  // write new average
		logic thr_mul;  // threshold and cash products
		logic commit;   // decide, update account, load result
	} ets_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/ets_ctrl.sv
// ----------------------------------------------------------------------------
// ets_ctrl
// Sequencer: steps one request through the datapath, owns the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ets_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire               out_ready,
	output ets_pkg::ets_cmd_t cmd
);
	import ets_pkg::*;

	ets_state_t state_q, state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_AVG;
				end
			end
			ST_AVG: begin
				cmd.avg_mul = 1'b1;
				state_d     = ST_UPD;
			end
			ST_UPD: begin
				cmd.ema_upd = 1'b1;
				state_d     = ST_MUL;
			end
			ST_MUL: begin
				cmd.thr_mul = 1'b1;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				// result slot free or draining this cycle
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					in_ready   = 1'b1;
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = ST_AVG;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`CHK_NEXT(a_accept_starts, clk, arst_n, in_valid && in_ready, state_q == ST_AVG)
	`CHK_NEXT(a_commit_shows, clk, arst_n, cmd.commit, out_valid_q)
	`CHK_NEXT(a_fin_waits, clk, arst_n, state_q == ST_FIN && out_valid_q && !out_ready,
		state_q == ST_FIN)

endmodule

`default_nettype wire

// File: rtl/core/ets_datapath.sv
// ----------------------------------------------------------------------------
// ets_datapath
// Average, threshold products, account state and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ets_datapath (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire  ets_pkg::ets_cmd_t            cmd,
	input  wire                                cfg_wen,
	input  wire  [ets_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  wire  [ets_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire                                mode,
	input  wire  [ets_pkg::PRICE_W-1:0]        trade_price,
	input  wire  [ets_pkg::PRICE_W-1:0]        best_bid,
	input  wire  [ets_pkg::PRICE_W-1:0]        best_ask,
	output logic                               order_made,
	output logic                               order_side,
	output logic [ets_pkg::PRICE_W-1:0]        order_price,
	output logic [ets_pkg::QTY_W-1:0]          order_quantity,
	output logic [ets_pkg::ID_W-1:0]           order_id,
	output logic [ets_pkg::PRICE_W-1:0]        average_now,
	output logic signed [ets_pkg::BAL_W-1:0]   balance_now,
	output logic signed [ets_pkg::POS_W-1:0]   position_now
);
	import ets_pkg::*;

	localparam logic [AVG_PROD_W-1:0] ROUND_ADD = AVG_PROD_W'((1 << ALPHA_W) - 1);
	localparam logic [BAL_W-1:0]      SIGN_BIT  = {1'b1, {(BAL_W-1){1'b0}}};
	localparam logic [POS_W-1:0]      POS_MAX   = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic [POS_W-1:0]      POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};

	// configuration
	logic [ALPHA_W-1:0] alpha_q;
	logic [QTY_W-1:0]   order_size_q;
	logic [RATIO_W-1:0] buy_ratio_q;
	logic [RATIO_W-1:0] sell_ratio_q;

	// account state
	logic [PRICE_W-1:0] ema_q;
	logic [BAL_W-1:0]   balance_q;
	logic [POS_W-1:0]   pos_q;
	logic [ID_W-1:0]    id_q;

	// request and work registers
	logic                  quote_s1;
	logic [PRICE_W-1:0]    price_s1;
	logic [PRICE_W-1:0]    sample_s1;
	logic                  above_s2;
	logic [AVG_PROD_W-1:0] avg_prod_s2;
	logic [THR_W-1:0]      buy_prod_s3;
	logic [THR_W-1:0]      sell_prod_s3;
	logic [CASH_W-1:0]     cash_prod_s3;

	// result register
	logic               res_made_q;
	logic               res_side_q;
	logic [PRICE_W-1:0] res_price_q;
	logic [QTY_W-1:0]   res_qty_q;
	logic [ID_W-1:0]    res_id_q;
	logic [PRICE_W-1:0] res_avg_q;
	logic [BAL_W-1:0]   res_bal_q;
	logic [POS_W-1:0]   res_pos_q;

	logic [PRICE_W:0]      quote_sum;
	logic [PRICE_W-1:0]    sample_in;
	logic                  above;
	logic [PRICE_W-1:0]    diff;
	logic [AVG_PROD_W-1:0] rnd_sum;
	logic [PRICE_W-1:0]    step_up;
	logic [PRICE_W-1:0]    step_dn;
	logic [PRICE_W-1:0]    ema_next;
	logic [THR_W-1:0]      price_scaled;
	logic                  is_buy;
	logic                  is_sell;
	logic                  made;
	logic [BAL_W-1:0]      off;
	logic [BAL_W-1:0]      cash_ext;
	logic [BAL_W:0]        off_sum;
	logic [BAL_W-1:0]      off_next;
	logic [POS_W:0]        pos_ext;
	logic [POS_W-1:0]      pos_next;

	// ---- sample select
	assign quote_sum = {1'b0, best_bid} + {1'b0, best_ask};
	assign sample_in = mode ? quote_sum[PRICE_W:1] : trade_price;

	// ---- average step
	assign above = sample_s1 >= ema_q;
	assign diff  = above ? (sample_s1 - ema_q) : (ema_q - sample_s1);

	// down step rounds the magnitude up so the result floors
	assign rnd_sum  = avg_prod_s2 + ROUND_ADD;
	assign step_up  = avg_prod_s2[AVG_PROD_W-1:ALPHA_W];
	assign step_dn  = rnd_sum[AVG_PROD_W-1:ALPHA_W];
	assign ema_next = (ema_q == '0) ? sample_s1 :
		(above_s2 ? (ema_q + step_up) : (ema_q - step_dn));

	// ---- decision
	assign price_scaled = THR_W'({price_s1, {RATIO_FRAC{1'b0}}});
	assign is_buy  = !quote_s1 && (price_scaled < buy_prod_s3);
	assign is_sell = !quote_s1 && !is_buy && (price_scaled > sell_prod_s3);
	assign made    = is_buy || is_sell;

	// ---- cash, offset-binary saturating add / subtract
	assign off      = balance_q ^ SIGN_BIT;
	assign cash_ext = BAL_W'(cash_prod_s3);
	assign off_sum  = {1'b0, off} + {1'b0, cash_ext};
	always_comb begin
		if (is_sell) begin
			off_next = off_sum[BAL_W] ? {BAL_W{1'b1}} : off_sum[BAL_W-1:0];
		end else begin
			off_next = (cash_ext > off) ? '0 : (off - cash_ext);
		end
	end

	// ---- position, clamp to signed range
	assign pos_ext = is_sell ? ({pos_q[POS_W-1], pos_q} - (POS_W+1)'(order_size_q)) :
		({pos_q[POS_W-1], pos_q} + (POS_W+1)'(order_size_q));
	always_comb begin
		if (pos_ext[POS_W] != pos_ext[POS_W-1]) begin
			pos_next = pos_ext[POS_W] ? POS_MIN : POS_MAX;
		end else begin
			pos_next = pos_ext[POS_W-1:0];
		end
	end

	// ---- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q      <= ALPHA_RST;
			order_size_q <= ORDER_SIZE_RST;
			buy_ratio_q  <= BUY_RATIO_RST;
			sell_ratio_q <= SELL_RATIO_RST;
		end else if (cfg_wen) begin
			case (cfg_addr)
				CFG_ALPHA:      alpha_q      <= cfg_wdata[ALPHA_W-1:0];
				CFG_ORDER_SIZE: order_size_q <= cfg_wdata[QTY_W-1:0];
				CFG_BUY_RATIO:  buy_ratio_q  <= cfg_wdata[RATIO_W-1:0];
				CFG_SELL_RATIO: sell_ratio_q <= cfg_wdata[RATIO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ---- account state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ema_q     <= '0;
			balance_q <= '0;
			pos_q     <= '0;
			id_q      <= '0;
		end else begin
			if (cmd.ema_upd) begin
				ema_q <= ema_next;
			end
			if (cmd.commit && made) begin
				balance_q <= off_next ^ SIGN_BIT;
				pos_q     <= pos_next;
				id_q      <= id_q + ID_W'(1);
			end
		end
	end

	// ---- work registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quote_s1  <= mode;
			price_s1  <= trade_price;
			sample_s1 <= sample_in;
		end
		if (cmd.avg_mul) begin
			above_s2    <= above;
			avg_prod_s2 <= AVG_PROD_W'(alpha_q) * AVG_PROD_W'(diff);
		end
		if (cmd.thr_mul) begin
			buy_prod_s3  <= THR_W'(ema_q) * THR_W'(buy_ratio_q);
			sell_prod_s3 <= THR_W'(ema_q) * THR_W'(sell_ratio_q);
			cash_prod_s3 <= CASH_W'(price_s1) * CASH_W'(order_size_q);
		end
		if (cmd.commit) begin
			res_made_q  <= made;
			res_side_q  <= is_sell ? SIDE_SELL : SIDE_BUY;
			res_price_q <= made ? price_s1 : '0;
			res_qty_q   <= made ? order_size_q : '0;
			res_id_q    <= made ? id_q : '0;
			res_avg_q   <= ema_q;
			res_bal_q   <= made ? (off_next ^ SIGN_BIT) : balance_q;
			res_pos_q   <= made ? pos_next : pos_q;
		end
	end

	assign order_made     = res_made_q;
	assign order_side     = res_side_q;
	assign order_price    = res_price_q;
	assign order_quantity = res_qty_q;
	assign order_id       = res_id_q;
	assign average_now    = res_avg_q;
	assign balance_now    = res_bal_q;
	assign position_now   = res_pos_q;

	`CHK_NEXT(a_id_step, clk, arst_n, cmd.commit && made, id_q == $past(id_q) + ID_W'(1))
	`CHK_NEXT(a_seed, clk, arst_n, cmd.ema_upd && ema_q == '0, ema_q == $past(sample_s1))
	`CHK_IMPLY(a_quote_no_order, clk, arst_n, cmd.commit && quote_s1, !made)

endmodule

`default_nettype wire

// File: rtl/core/ema_threshold_trade_signal.sv
// ----------------------------------------------------------------------------
// ema_threshold_trade_signal
// Mean-reversion trade signal on an exponential moving average. Each request
// is a trade (one price) or a quote (bid and ask); it moves the average and,
// for a trade far enough below or above it, places a buy or sell order that
// updates the saturating cash balance and position. Every request gives one
// result with the order fields (zero when no order) and the account state.
// A request, once accepted, runs through alpha multiply, average write,
// threshold/cash multiplies, then decide and load the result register.
// The steps follow the chain of dependent multiplies through the average;
// a new request is taken in the same cycle the previous result is loaded.
// A result not yet taken holds the last step until the output is free.
// Configuration is written through cfg_wen/cfg_addr/cfg_wdata; the user
// must do so only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ema_threshold_trade_signal (
	input  wire                                clk,
	input  wire                                arst_n,
	// configuration write port
	input  wire                                cfg_wen,
	input  wire  [ets_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  wire  [ets_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// request channel
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire                                mode,
	input  wire  [ets_pkg::PRICE_W-1:0]        trade_price,
	input  wire  [ets_pkg::PRICE_W-1:0]        best_bid,
	input  wire  [ets_pkg::PRICE_W-1:0]        best_ask,
	// result channel
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic                               order_made,
	output logic                               order_side,
	output logic [ets_pkg::PRICE_W-1:0]        order_price,
	output logic [ets_pkg::QTY_W-1:0]          order_quantity,
	output logic [ets_pkg::ID_W-1:0]           order_id,
	output logic [ets_pkg::PRICE_W-1:0]        average_now,
	output logic signed [ets_pkg::BAL_W-1:0]   balance_now,
	output logic signed [ets_pkg::POS_W-1:0]   position_now
);
	import ets_pkg::*;

	// command bundle from the sequencer to the datapath
	ets_cmd_t cmd;

	// Sequencer: IDLE -> AVG -> UPD -> MUL -> FIN, FIN commits when the
	// result register is free and may take the next request right away.
	ets_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Datapath: configuration registers, average, Q33.30 threshold products,
	// price*quantity, saturating balance/position and the result register.
	ets_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_wen        (cfg_wen),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.mode           (mode),
		.trade_price    (trade_price),
		.best_bid       (best_bid),
		.best_ask       (best_ask),
		.order_made     (order_made),
		.order_side     (order_side),
		.order_price    (order_price),
		.order_quantity (order_quantity),
		.order_id       (order_id),
		.average_now    (average_now),
		.balance_now    (balance_now),
		.position_now   (position_now)
	);

endmodule

`default_nettype wire
